// ===== rtl/core/mtss_pkg.sv =====
// Shared types and constants for the multi-track step sequencer.
// Depends on nothing; used by the controller, the datapath and the top level.
package mtss_pkg;

	localparam logic [1:0] REQ_TICK   = 2'd0;
	localparam logic [1:0] REQ_SYNC   = 2'd1;
	localparam logic [1:0] REQ_WRITE  = 2'd2;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	localparam logic [2:0] CFG_ENABLED   = 3'd0;
	localparam logic [2:0] CFG_SPS       = 3'd1;
	localparam logic [2:0] CFG_GLIDE     = 3'd2;
	localparam logic [2:0] CFG_LENGTHS   = 3'd3;
	localparam logic [2:0] CFG_MODES     = 3'd4;
	localparam logic [2:0] CFG_SMOOTH    = 3'd5;

	localparam logic [1:0] MODE_FWD    = 2'd0;
	localparam logic [1:0] MODE_BWD    = 2'd1;
	localparam logic [1:0] MODE_BOUNCE = 2'd2;
	localparam logic [1:0] MODE_RAND   = 2'd3;

	localparam logic [31:0] LCG_MUL = 32'd1664525;
	localparam logic [31:0] LCG_ADD = 32'd1013904223;
	localparam logic [16:0] MAX_ADVANCES = 17'd65536;

	localparam logic [16:0] GF_MIN = 17'd655;
	localparam logic [16:0] GF_MAX = 17'd65536;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // add the samples to the counter while enabled
		logic sync_clr;  // clear the counter for key sync
		logic cnt_sub;   // subtract one step length from the counter
		logic cnt_mod;   // iterative reduction of a backlog
		logic adv;       // advance the selected track
		logic rem;       // one step of the position remainder
		logic tbl_wr;    // write the step table
		logic rd;        // read the step table for the selected track
		logic upd;       // update the selected track's output value
		logic sync_rd;   // read step 0 of the selected track
		logic sync_trk;  // restart the selected track
		logic emit;      // present the selected track as a result
		logic [2:0] trk; // selected track
	} mtss_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic cnt_ge;    // counter at or above the step length
		logic rem_need;  // the selected track's advance needs a remainder
		logic rem_done;  // the remainder finishes in this cycle
	} mtss_sts_t;

endpackage

// ===== rtl/core/multi_track_mod_step_sequencer.sv =====
// Top level of the multi-track step sequencer: configuration registers and wiring.
// Depends on mtss_pkg, mtss_ctrl and mtss_dp.
// An enabled tick keeps busy high through one counter check when no step falls due, then
// a table read and an output update per track, then one result per track. Each step
// advance adds one counter check and, per track, an advance plus a bit-serial remainder of
// a five-bit dividend for forward and backward or of the 32-bit LCG value for random;
// bounce needs no remainder. The single table read port and the shared remainder unit make
// these steps sequential. A disabled tick goes straight to the results. A counter left over
// after 65536 advances is reduced one subtraction a cycle. Key sync reads step 0 and
// restarts each selected track in turn, and a table write leaves busy low. Results follow in
// the cycle after their emit state, one per cycle on strobe, track 0 first, and cannot be
// held off; start is taken only while busy is low.
module multi_track_mod_step_sequencer #(
	parameter int TRACK_COUNT = 6,
	parameter int STEP_COUNT  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [15:0] num_samples,
	input  logic [2:0]  first_track,
	input  logic [3:0]  track_count,
	input  logic [2:0]  write_track,
	input  logic [3:0]  write_step,
	input  logic [15:0] step_value,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output logic        strobe,
	output logic [2:0]  track_index,
	output logic [15:0] track_value,
	output logic [3:0]  current_position,
	output logic        last
);

	logic        enabled_q;
	logic [31:0] sps_q;
	logic [16:0] glide_q;
	logic [23:0] lengths_q;
	logic [11:0] modes_q;
	logic [5:0]  smooth_q;
	mtss_pkg::mtss_cmd_t cmd;
	mtss_pkg::mtss_sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b1;
			sps_q <= 32'd1411200;
			glide_q <= 17'd18500;
			lengths_q <= 24'hFFFFFF;
			modes_q <= '0;
			smooth_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				mtss_pkg::CFG_ENABLED: enabled_q <= cfg_data[0];
				mtss_pkg::CFG_SPS:     sps_q <= cfg_data;
				mtss_pkg::CFG_GLIDE:   glide_q <= cfg_data[16:0];
				mtss_pkg::CFG_LENGTHS: lengths_q <= cfg_data[23:0];
				mtss_pkg::CFG_MODES:   modes_q <= cfg_data[11:0];
				mtss_pkg::CFG_SMOOTH:  smooth_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	mtss_ctrl #(.TRACK_COUNT(TRACK_COUNT)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .req_type(req_type),
		.first_track(first_track), .track_count(track_count), .enabled(enabled_q),
		.sts(sts), .cmd(cmd), .busy(busy)
	);

	mtss_dp #(.TRACK_COUNT(TRACK_COUNT), .STEP_COUNT(STEP_COUNT)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.num_samples(num_samples), .write_track(write_track), .write_step(write_step),
		.step_value(step_value), .enabled(enabled_q), .samples_per_step(sps_q),
		.glide_factor(glide_q), .track_lengths(lengths_q), .track_modes(modes_q),
		.track_smooth(smooth_q), .out_valid(strobe), .track_index(track_index),
		.track_value(track_value), .current_position(current_position), .last(last)
	);

	a_last_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe) else $error("result after final track");
	a_busy_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy) else $error("result while idle");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req_type == mtss_pkg::REQ_WRITE |=> !busy)
		else $error("write stayed busy");

endmodule

// ===== rtl/core/mtss_ctrl.sv =====
// Controller state machine for the multi-track step sequencer.
// Depends on mtss_pkg; drives the datapath only through command and status.
module mtss_ctrl #(
	parameter int TRACK_COUNT = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          req_type,
	input  logic [2:0]          first_track,
	input  logic [3:0]          track_count,
	input  logic                enabled,
	input  mtss_pkg::mtss_sts_t sts,
	output mtss_pkg::mtss_cmd_t cmd,
	output logic                busy
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_COUNT, ST_ADV, ST_REM, ST_MOD, ST_READ, ST_UPD, ST_EMIT,
		ST_SYNC_RD, ST_SYNC
	} state_t;

	localparam logic [2:0] LAST_TRK = 3'(TRACK_COUNT - 1);

	state_t state_q;
	logic [2:0] trk_q;
	logic [16:0] nadv_q;
	logic [3:0] sync_end_q;
	logic [3:0] sync_end;
	logic [4:0] sum;
	logic acc;

	always_comb begin
		sum = {2'b0, first_track} + {1'b0, track_count};
		if (sum > 5'(TRACK_COUNT)) begin
			sync_end = 4'(TRACK_COUNT);
		end else begin
			sync_end = sum[3:0];
		end
	end

	always_comb begin
		cmd = '0;
		cmd.trk = trk_q;
		acc = (state_q == ST_IDLE) && start;
		cmd.load = acc && (req_type == mtss_pkg::REQ_TICK);
		cmd.tbl_wr = acc && (req_type == mtss_pkg::REQ_WRITE);
		cmd.sync_clr = acc && (req_type == mtss_pkg::REQ_SYNC);
		case (state_q)
			ST_COUNT: begin
				cmd.cnt_sub = sts.cnt_ge && (nadv_q != mtss_pkg::MAX_ADVANCES);
			end
			ST_ADV:     cmd.adv = 1'b1;
			ST_REM:     cmd.rem = 1'b1;
			ST_MOD:     cmd.cnt_mod = 1'b1;
			ST_READ:    cmd.rd = 1'b1;
			ST_UPD:     cmd.upd = 1'b1;
			ST_EMIT:    cmd.emit = 1'b1;
			ST_SYNC_RD: cmd.sync_rd = 1'b1;
			ST_SYNC:    cmd.sync_trk = 1'b1;
			default: ;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			trk_q <= '0;
			nadv_q <= '0;
			sync_end_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					nadv_q <= '0;
					trk_q <= '0;
					if (start) begin
						case (req_type)
							mtss_pkg::REQ_TICK: begin
								state_q <= enabled ? ST_COUNT : ST_EMIT;
							end
							mtss_pkg::REQ_SYNC: begin
								trk_q <= first_track;
								sync_end_q <= sync_end;
								if ({1'b0, first_track} < sync_end) begin
									state_q <= ST_SYNC_RD;
								end
							end
							default: ;
						endcase
					end
				end
				ST_COUNT: begin
					trk_q <= '0;
					if (!sts.cnt_ge) begin
						state_q <= ST_READ;
					end else if (nadv_q == mtss_pkg::MAX_ADVANCES) begin
						state_q <= ST_MOD;
					end else begin
						nadv_q <= nadv_q + 17'd1;
						state_q <= ST_ADV;
					end
				end
				ST_ADV: begin
					if (sts.rem_need) begin
						state_q <= ST_REM;
					end else if (trk_q == LAST_TRK) begin
						trk_q <= '0;
						state_q <= ST_COUNT;
					end else begin
						trk_q <= trk_q + 3'd1;
					end
				end
				ST_REM: begin
					if (sts.rem_done) begin
						if (trk_q == LAST_TRK) begin
							trk_q <= '0;
							state_q <= ST_COUNT;
						end else begin
							trk_q <= trk_q + 3'd1;
							state_q <= ST_ADV;
						end
					end
				end
				ST_MOD: begin
					if (!sts.cnt_ge) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_UPD;
				ST_UPD: begin
					if (trk_q == LAST_TRK) begin
						trk_q <= '0;
						state_q <= ST_EMIT;
					end else begin
						trk_q <= trk_q + 3'd1;
						state_q <= ST_READ;
					end
				end
				ST_EMIT: begin
					if (trk_q == LAST_TRK) begin
						trk_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						trk_q <= trk_q + 3'd1;
					end
				end
				ST_SYNC_RD: state_q <= ST_SYNC;
				ST_SYNC: begin
					if ({1'b0, trk_q} + 4'd1 >= sync_end_q) begin
						state_q <= ST_IDLE;
					end else begin
						trk_q <= trk_q + 3'd1;
						state_q <= ST_SYNC_RD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/mtss_dp.sv =====
// Datapath of the multi-track step sequencer: counter, LCG, track state and table.
// Depends on mtss_pkg; driven by mtss_ctrl through command signals.
module mtss_dp #(
	parameter int TRACK_COUNT = 6,
	parameter int STEP_COUNT  = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mtss_pkg::mtss_cmd_t cmd,
	output mtss_pkg::mtss_sts_t sts,
	input  logic [15:0]         num_samples,
	input  logic [2:0]          write_track,
	input  logic [3:0]          write_step,
	input  logic [15:0]         step_value,
	input  logic                enabled,
	input  logic [31:0]         samples_per_step,
	input  logic [16:0]         glide_factor,
	input  logic [23:0]         track_lengths,
	input  logic [11:0]         track_modes,
	input  logic [5:0]          track_smooth,
	output logic                out_valid,
	output logic [2:0]          track_index,
	output logic [15:0]         track_value,
	output logic [3:0]          current_position,
	output logic                last
);

	localparam int DEPTH = TRACK_COUNT * STEP_COUNT;
	localparam int AW = $clog2(DEPTH);

	logic [15:0] table_q [DEPTH];
	logic [15:0] rd_q;
	logic [3:0]  pos_q [TRACK_COUNT];
	logic        up_q [TRACK_COUNT];
	logic [15:0] sm_q [TRACK_COUNT];
	logic [33:0] cnt_q;
	logic [31:0] lcg_q;
	logic [31:0] dvd_q;
	logic [3:0]  rem_q;
	logic [5:0]  rem_cnt_q;
	logic [33:0] sps;
	logic [16:0] gf;
	logic [4:0]  len;
	logic [1:0]  mode;
	logic        smooth;
	logic [3:0]  p;
	logic [3:0]  p_nxt;
	logic        up_nxt;
	logic [31:0] lcg_nxt;
	logic [4:0]  small_dvd;
	logic [4:0]  rem_sh;
	logic [4:0]  rem_nxt;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic [15:0] cur;
	logic [15:0] diff;
	logic [32:0] prod;
	logic [16:0] q;
	logic [15:0] glided;
	logic [33:0] shifted;

	always_comb begin
		sps = (samples_per_step < 32'd256) ? 34'd256 : {2'b0, samples_per_step};
		gf = glide_factor;
		if (gf < mtss_pkg::GF_MIN) gf = mtss_pkg::GF_MIN;
		if (gf > mtss_pkg::GF_MAX) gf = mtss_pkg::GF_MAX;
		len = (cmd.trk < 3'd6) ? {1'b0, track_lengths[4*cmd.trk +: 4]} + 5'd1 : 5'd1;
		if (len > 5'(STEP_COUNT)) len = 5'(STEP_COUNT);
		mode = (cmd.trk < 3'd6) ? track_modes[2*cmd.trk +: 2] : mtss_pkg::MODE_FWD;
		smooth = (cmd.trk < 3'd6) ? track_smooth[cmd.trk] : 1'b0;
		p = pos_q[cmd.trk];
		up_nxt = up_q[cmd.trk];
		lcg_nxt = lcg_q * mtss_pkg::LCG_MUL + mtss_pkg::LCG_ADD;
		p_nxt = p;
		case (mode)
			mtss_pkg::MODE_BOUNCE: begin
				if (up_q[cmd.trk]) begin
					if ({1'b0, p} + 5'd1 >= len - 5'd1) begin
						p_nxt = 4'(len - 5'd1);
						up_nxt = 1'b0;
					end else begin
						p_nxt = p + 4'd1;
					end
				end else begin
					if (p <= 4'd1) begin
						p_nxt = 4'd0;
						up_nxt = 1'b1;
					end else begin
						p_nxt = p - 4'd1;
					end
				end
			end
			default: ;
		endcase
		// Forward, backward and random positions are remainders by the length, one bit a cycle.
		small_dvd = (mode == mtss_pkg::MODE_BWD) ? ({1'b0, p} + len - 5'd1)
			: ({1'b0, p} + 5'd1);
		rem_sh = {rem_q, dvd_q[31]};
		rem_nxt = (rem_sh >= len) ? rem_sh - len : rem_sh;
		rd_addr = AW'(cmd.trk * STEP_COUNT + p);
		wr_addr = AW'(write_track * STEP_COUNT + write_step);
		cur = sm_q[cmd.trk];
		diff = (rd_q >= cur) ? rd_q - cur : cur - rd_q;
		prod = {17'd0, diff} * {16'd0, gf} + 33'd32768;
		q = prod[32:16];
		glided = (rd_q >= cur) ? cur + q[15:0] : cur - q[15:0];
		shifted = {10'd0, num_samples, 8'd0};
		sts.cnt_ge = (cnt_q >= sps);
		sts.rem_need = (mode != mtss_pkg::MODE_BOUNCE);
		sts.rem_done = (rem_cnt_q == 6'd1);
	end

	always_ff @(posedge clk) begin
		if (cmd.tbl_wr && ({1'b0, write_track} < 4'(TRACK_COUNT))
			&& ({1'b0, write_step} < 5'(STEP_COUNT))) begin
			table_q[wr_addr] <= step_value;
		end
		if (cmd.rd || cmd.sync_rd) begin
			rd_q <= table_q[cmd.sync_rd ? AW'(cmd.trk * STEP_COUNT) : rd_addr];
		end
		track_index <= cmd.trk;
		track_value <= enabled ? sm_q[cmd.trk] : 16'd0;
		current_position <= pos_q[cmd.trk];
		last <= (cmd.trk == 3'(TRACK_COUNT - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			lcg_q <= 32'd1;
			dvd_q <= '0;
			rem_q <= '0;
			rem_cnt_q <= '0;
			out_valid <= 1'b0;
			for (int i = 0; i < TRACK_COUNT; i++) begin
				pos_q[i] <= '0;
				up_q[i] <= 1'b1;
				sm_q[i] <= '0;
			end
		end else begin
			out_valid <= cmd.emit;
			if (cmd.sync_clr) begin
				cnt_q <= '0;
			end else if (cmd.load && enabled) begin
				cnt_q <= cnt_q + shifted;
			end else if ((cmd.cnt_sub || cmd.cnt_mod) && sts.cnt_ge) begin
				cnt_q <= cnt_q - sps;
			end
			if (cmd.adv) begin
				if (mode == mtss_pkg::MODE_BOUNCE) begin
					pos_q[cmd.trk] <= p_nxt;
					up_q[cmd.trk] <= up_nxt;
				end else begin
					rem_q <= '0;
					if (mode == mtss_pkg::MODE_RAND) begin
						lcg_q <= lcg_nxt;
						dvd_q <= lcg_nxt;
						rem_cnt_q <= 6'd32;
					end else begin
						dvd_q <= {small_dvd, 27'd0};
						rem_cnt_q <= 6'd5;
					end
				end
			end
			if (cmd.rem) begin
				rem_q <= rem_nxt[3:0];
				dvd_q <= {dvd_q[30:0], 1'b0};
				rem_cnt_q <= rem_cnt_q - 6'd1;
				if (rem_cnt_q == 6'd1) begin
					pos_q[cmd.trk] <= rem_nxt[3:0];
				end
			end
			if (cmd.upd) begin
				sm_q[cmd.trk] <= smooth ? glided : rd_q;
			end
			if (cmd.sync_trk) begin
				pos_q[cmd.trk] <= '0;
				up_q[cmd.trk] <= 1'b1;
				sm_q[cmd.trk] <= rd_q;
			end
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for multi_track_mod_step_sequencer: directed table, then random phases.
// Depends on mtss_pkg and the block; results are checked against a built-in sequencer model.
module tb;

	localparam int TRACKS = 6;
	localparam int STEPS = 16;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct {
		logic [2:0] idx;
		logic [15:0] val;
		logic [3:0] pos;
		logic last;
	} track_out_t;

	typedef struct {
		bit is_cfg;
		logic [2:0] cfg_idx;
		logic [31:0] cfg_val;
		logic [1:0] req;
		logic [15:0] ns;
		logic [2:0] ft;
		logic [3:0] tc;
		logic [2:0] wt;
		logic [3:0] ws;
		logic [15:0] sv;
		bit chk;
		logic [15:0] exp_val;
		logic [3:0] exp_pos;
	} stim_row_t;

	logic clk, arst_n, start, busy, cfg_we, strobe, last;
	logic [1:0] req_type;
	logic [15:0] num_samples, step_value, track_value;
	logic [2:0] first_track, write_track, cfg_index, track_index;
	logic [3:0] track_count, write_step, current_position;
	logic [31:0] cfg_data;

	// Sequencer state as the block should hold it.
	logic en_r;
	logic [31:0] sps_r;
	logic [16:0] glide_r;
	logic [23:0] lengths_r;
	logic [11:0] modes_r;
	logic [5:0] smooth_r;
	logic [15:0] steps_tab [TRACKS][STEPS];
	int pos_r [TRACKS];
	bit going_up [TRACKS];
	logic [15:0] out_val [TRACKS];
	longint unsigned samp_cnt;
	logic [31:0] lcg;

	track_out_t pending_outs[$];
	int errors = 0;
	int items_sent = 0;
	int outs_checked = 0;
	longint cycles = 0;

	multi_track_mod_step_sequencer u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .num_samples(num_samples), .first_track(first_track),
		.track_count(track_count), .write_track(write_track), .write_step(write_step),
		.step_value(step_value), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .strobe(strobe), .track_index(track_index),
		.track_value(track_value), .current_position(current_position), .last(last)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	function automatic void step_tracks();
		int len;
		logic [1:0] mode;
		for (int t = 0; t < TRACKS; t++) begin
			len = int'(lengths_r[4*t +: 4]) + 1;
			mode = modes_r[2*t +: 2];
			case (mode)
				mtss_pkg::MODE_FWD: pos_r[t] = (pos_r[t] + 1) % len;
				mtss_pkg::MODE_BWD: pos_r[t] = (pos_r[t] + len - 1) % len;
				mtss_pkg::MODE_BOUNCE: begin
					if (going_up[t]) begin
						pos_r[t]++;
						if (pos_r[t] >= len - 1) begin
							pos_r[t] = len - 1;
							going_up[t] = 0;
						end
					end else begin
						pos_r[t]--;
						if (pos_r[t] <= 0) begin
							pos_r[t] = 0;
							going_up[t] = 1;
						end
					end
				end
				default: begin
					lcg = lcg * mtss_pkg::LCG_MUL + mtss_pkg::LCG_ADD;
					pos_r[t] = int'(lcg % 32'(len));
				end
			endcase
		end
	endfunction

	function automatic void predict(logic [1:0] rq, logic [15:0] ns, logic [2:0] ft,
			logic [3:0] tc, logic [2:0] wt, logic [3:0] ws, logic [15:0] sv);
		int stop;
		longint unsigned sps, gf, d, q;
		int n;
		track_out_t o;
		if (rq == mtss_pkg::REQ_SYNC) begin
			stop = int'(ft) + int'(tc);
			if (stop > TRACKS) stop = TRACKS;
			samp_cnt = 0;
			for (int t = int'(ft); t < stop; t++) begin
				pos_r[t] = 0;
				going_up[t] = 1;
				out_val[t] = steps_tab[t][0];
			end
		end else if (rq == mtss_pkg::REQ_WRITE) begin
			if (wt < TRACKS) steps_tab[wt][ws] = sv;
		end else if (rq == mtss_pkg::REQ_TICK) begin
			if (en_r) begin
				sps = (sps_r < 256) ? 256 : 64'(sps_r);
				gf = 64'(glide_r);
				if (gf < mtss_pkg::GF_MIN) gf = 64'(mtss_pkg::GF_MIN);
				if (gf > mtss_pkg::GF_MAX) gf = 64'(mtss_pkg::GF_MAX);
				samp_cnt += longint'(ns) << 8;
				n = 0;
				while (samp_cnt >= sps && n < int'(mtss_pkg::MAX_ADVANCES)) begin
					samp_cnt -= sps;
					step_tracks();
					n++;
				end
				samp_cnt = samp_cnt % sps;
				for (int t = 0; t < TRACKS; t++) begin
					if (smooth_r[t]) begin
						if (steps_tab[t][pos_r[t]] >= out_val[t]) begin
							d = 64'(steps_tab[t][pos_r[t]] - out_val[t]);
							q = (d * gf + 32768) >> 16;
							out_val[t] = 16'(64'(out_val[t]) + q);
						end else begin
							d = 64'(out_val[t] - steps_tab[t][pos_r[t]]);
							q = (d * gf + 32768) >> 16;
							out_val[t] = 16'(64'(out_val[t]) - q);
						end
					end else begin
						out_val[t] = steps_tab[t][pos_r[t]];
					end
				end
			end
			for (int t = 0; t < TRACKS; t++) begin
				o.idx = 3'(t);
				o.val = en_r ? out_val[t] : 16'd0;
				o.pos = 4'(pos_r[t]);
				o.last = (t == TRACKS - 1);
				pending_outs.push_back(o);
			end
		end
	endfunction

	always @(posedge clk) begin
		track_out_t e;
		if (arst_n && strobe) begin
			if (pending_outs.size() == 0) begin
				$error("result for track %0d with nothing expected", track_index);
				errors++;
			end else begin
				e = pending_outs.pop_front();
				outs_checked++;
				if (track_index !== e.idx) begin
					$error("track_index expected %0d actual %0d", e.idx, track_index);
					errors++;
				end
				if (track_value !== e.val) begin
					$error("track_value expected %h actual %h", e.val, track_value);
					errors++;
				end
				if (current_position !== e.pos) begin
					$error("current_position expected %0d actual %0d", e.pos, current_position);
					errors++;
				end
				if (last !== e.last) begin
					$error("last expected %b actual %b", e.last, last);
					errors++;
				end
			end
		end
	end

	task automatic issue(logic [1:0] rq, logic [15:0] ns, logic [2:0] ft, logic [3:0] tc,
			logic [2:0] wt, logic [3:0] ws, logic [15:0] sv);
		start <= 1'b1;
		req_type <= rq;
		num_samples <= ns;
		first_track <= ft;
		track_count <= tc;
		write_track <= wt;
		write_step <= ws;
		step_value <= sv;
		do @(posedge clk); while (busy);
		predict(rq, ns, ft, tc, wt, ws, sv);
		items_sent++;
	endtask

	task automatic settle();
		start <= 1'b0;
		while (pending_outs.size() != 0) @(posedge clk);
		do @(posedge clk); while (busy);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			mtss_pkg::CFG_ENABLED: en_r = val[0];
			mtss_pkg::CFG_SPS: sps_r = val;
			mtss_pkg::CFG_GLIDE: glide_r = val[16:0];
			mtss_pkg::CFG_LENGTHS: lengths_r = val[23:0];
			mtss_pkg::CFG_MODES: modes_r = val[11:0];
			mtss_pkg::CFG_SMOOTH: smooth_r = val[5:0];
			default: ;
		endcase
	endtask

	stim_row_t dir_rows [] = '{
		'{0, mtss_pkg::CFG_ENABLED, 0, mtss_pkg::REQ_TICK, 16'd0,
			0, 0, 0, 0, 0, 0, 16'h0, 4'd0},
		'{0, mtss_pkg::CFG_ENABLED, 0, mtss_pkg::REQ_TICK, 16'hFFFF,
			0, 0, 0, 0, 0, 0, 16'h0, 4'd0},
		'{0, mtss_pkg::CFG_ENABLED, 0, mtss_pkg::REQ_WRITE, 0,
			0, 0, 3'd0, 4'd0, 16'hFFFF, 0, 16'h0, 4'd0},
		'{0, mtss_pkg::CFG_ENABLED, 0, mtss_pkg::REQ_WRITE, 0,
			0, 0, 3'd7, 4'd15, 16'h1234, 0, 16'h0, 4'd0},
		'{0, mtss_pkg::CFG_ENABLED, 0, mtss_pkg::REQ_WRITE, 0,
			0, 0, 3'd6, 4'd3, 16'h0000, 0, 16'h0, 4'd0},
		'{0, mtss_pkg::CFG_ENABLED, 0, mtss_pkg::REQ_UNUSED, 16'hFFFF,
			3'd7, 4'd15, 3'd7, 4'd15, 16'hFFFF, 0, 16'h0, 4'd0},
		'{0, mtss_pkg::CFG_ENABLED, 0, mtss_pkg::REQ_SYNC, 0,
			3'd0, 4'd8, 0, 0, 0, 0, 16'h0, 4'd0},
		'{0, mtss_pkg::CFG_ENABLED, 0, mtss_pkg::REQ_TICK, 16'd0,
			0, 0, 0, 0, 0, 1, 16'hFFFF, 4'd0},
		'{1, mtss_pkg::CFG_ENABLED, 32'd0, 0, 0, 0, 0, 0, 0, 0, 0, 16'h0, 4'd0},
		'{0, mtss_pkg::CFG_ENABLED, 0, mtss_pkg::REQ_TICK, 16'd5000,
			0, 0, 0, 0, 0, 1, 16'h0, 4'd0},
		'{0, mtss_pkg::CFG_ENABLED, 0, mtss_pkg::REQ_SYNC, 0,
			3'd7, 4'd0, 0, 0, 0, 0, 16'h0, 4'd0},
		'{0, mtss_pkg::CFG_ENABLED, 0, mtss_pkg::REQ_SYNC, 0,
			3'd2, 4'd3, 0, 0, 0, 0, 16'h0, 4'd0},
		'{1, mtss_pkg::CFG_ENABLED, 32'd1, 0, 0, 0, 0, 0, 0, 0, 0, 16'h0, 4'd0},
		'{1, mtss_pkg::CFG_SPS, 32'd0, 0, 0, 0, 0, 0, 0, 0, 0, 16'h0, 4'd0},
		'{1, mtss_pkg::CFG_MODES, 32'hE4E, 0, 0, 0, 0, 0, 0, 0, 0, 16'h0, 4'd0},
		'{1, mtss_pkg::CFG_LENGTHS, 32'h0F3100, 0, 0, 0, 0, 0, 0, 0, 0, 16'h0, 4'd0},
		'{1, mtss_pkg::CFG_SMOOTH, 32'h2A, 0, 0, 0, 0, 0, 0, 0, 0, 16'h0, 4'd0},
		'{1, mtss_pkg::CFG_GLIDE, 32'd0, 0, 0, 0, 0, 0, 0, 0, 0, 16'h0, 4'd0},
		'{0, mtss_pkg::CFG_ENABLED, 0, mtss_pkg::REQ_TICK, 16'd3,
			0, 0, 0, 0, 0, 0, 16'h0, 4'd0},
		'{0, mtss_pkg::CFG_ENABLED, 0, mtss_pkg::REQ_TICK, 16'd1,
			0, 0, 0, 0, 0, 0, 16'h0, 4'd0},
		'{1, mtss_pkg::CFG_GLIDE, 32'h1FFFF, 0, 0, 0, 0, 0, 0, 0, 0, 16'h0, 4'd0},
		'{0, mtss_pkg::CFG_ENABLED, 0, mtss_pkg::REQ_TICK, 16'd2,
			0, 0, 0, 0, 0, 0, 16'h0, 4'd0},
		'{0, mtss_pkg::CFG_ENABLED, 0, mtss_pkg::REQ_TICK, 16'd0,
			0, 0, 0, 0, 0, 0, 16'h0, 4'd0},
		'{0, mtss_pkg::CFG_ENABLED, 0, mtss_pkg::REQ_SYNC, 0,
			3'd1, 4'd15, 0, 0, 0, 0, 16'h0, 4'd0},
		'{0, mtss_pkg::CFG_ENABLED, 0, mtss_pkg::REQ_TICK, 16'd7,
			0, 0, 0, 0, 0, 0, 16'h0, 4'd0}
	};

	initial begin
		int pick, max_ns;
		longint unsigned sps_eff;
		bit idling;
		stim_row_t r;
		arst_n = 1'b0;
		start = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_type = '0;
		num_samples = '0;
		first_track = '0;
		track_count = '0;
		write_track = '0;
		write_step = '0;
		step_value = '0;
		en_r = 1'b1;
		sps_r = 32'd1411200;
		glide_r = 17'd18500;
		lengths_r = 24'hFFFFFF;
		modes_r = '0;
		smooth_r = '0;
		samp_cnt = 0;
		lcg = 32'd1;
		for (int t = 0; t < TRACKS; t++) begin
			pos_r[t] = 0;
			going_up[t] = 1;
			out_val[t] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every table entry is loaded before anything can read it.
		for (int t = 0; t < TRACKS; t++)
			for (int s = 0; s < STEPS; s++)
				issue(mtss_pkg::REQ_WRITE, 16'd0, 3'd0, 4'd0, 3'(t), 4'(s),
					16'($urandom_range(0, 16'hFFFF)));

		foreach (dir_rows[i]) begin
			r = dir_rows[i];
			if (r.is_cfg) begin
				settle();
				write_reg(r.cfg_idx, r.cfg_val);
			end else begin
				issue(r.req, r.ns, r.ft, r.tc, r.wt, r.ws, r.sv);
				if (r.chk && (pending_outs[$-5].val !== r.exp_val
						|| pending_outs[$-5].pos !== r.exp_pos)) begin
					$error("directed row %0d: track 0 expected %h/%0d, model gives %h/%0d",
						i, r.exp_val, r.exp_pos, pending_outs[$-5].val, pending_outs[$-5].pos);
					errors++;
				end
			end
		end

		for (int ph = 0; ph < 8; ph++) begin
			settle();
			write_reg(mtss_pkg::CFG_ENABLED, (ph == 3) ? 32'd0 : $urandom);
			if (ph != 3) write_reg(mtss_pkg::CFG_ENABLED, 32'd1);
			case (ph % 4)
				0: write_reg(mtss_pkg::CFG_SPS, $urandom_range(0, 255));
				1: write_reg(mtss_pkg::CFG_SPS, 32'hFFFFFFFF);
				2: write_reg(mtss_pkg::CFG_SPS, 32'd1411200);
				default: write_reg(mtss_pkg::CFG_SPS, $urandom);
			endcase
			write_reg(mtss_pkg::CFG_GLIDE, $urandom);
			write_reg(mtss_pkg::CFG_LENGTHS, $urandom);
			write_reg(mtss_pkg::CFG_MODES, $urandom);
			write_reg(mtss_pkg::CFG_SMOOTH, $urandom);
			sps_eff = (sps_r < 256) ? 256 : 64'(sps_r);
			max_ns = ((sps_eff * 40) >> 8) > 65535 ? 65535 : int'((sps_eff * 40) >> 8);
			idling = (ph < 7);
			for (int k = 0; k < 6; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 70)
					issue(mtss_pkg::REQ_TICK, 16'($urandom_range(0, max_ns)), 3'($urandom),
						4'($urandom), 3'($urandom), 4'($urandom), 16'($urandom));
				else if (pick < 85)
					issue(mtss_pkg::REQ_WRITE, 16'($urandom), 3'($urandom), 4'($urandom),
						3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
						16'($urandom_range(0, 16'hFFFF)));
				else if (pick < 95)
					issue(mtss_pkg::REQ_SYNC, 16'($urandom), 3'($urandom_range(0, 7)),
						4'($urandom_range(0, 15)), 3'($urandom), 4'($urandom),
						16'($urandom));
				else
					issue(mtss_pkg::REQ_UNUSED, 16'($urandom), 3'($urandom), 4'($urandom),
						3'($urandom), 4'($urandom), 16'($urandom));
				if (idling && $urandom_range(0, 2) == 0) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 17)) @(posedge clk);
				end
			end
		end

		settle();
		$display("Sent %0d items over eight register settings; %0d track results checked.",
			items_sent, outs_checked);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/core/mtss_pkg.sv
rtl/core/mtss_ctrl.sv
rtl/core/mtss_dp.sv
rtl/core/multi_track_mod_step_sequencer.sv
tb/sv/tb.sv
